// File: rtl/rfb_pkg.sv
// ----------------------------------------------------------------------------
// RGB444 frame buffer blitter package
// Shared types, constants and helper functions for the blitter core.
// ----------------------------------------------------------------------------
package rfb_pkg;

   // Display geometry and frame store sizing.
   localparam int DISP_WIDTH  = 132;
   localparam int DISP_HEIGHT = 132;
   localparam int NPIX        = DISP_WIDTH * DISP_HEIGHT;
   localparam int ADDR_W      = $clog2(NPIX);
   localparam int CNT_W       = $clog2(NPIX + 1);
   localparam int PIX_W       = 12;

   // Refresh command bytes.
   localparam logic [7:0] CMD_COLUMN = 8'h2A;
   localparam logic [7:0] CMD_PAGE   = 8'h2B;
   localparam logic [7:0] CMD_WRITE  = 8'h2C;

   // Input function codes.
   localparam logic [1:0] FN_CLEAR = 2'd0;
   localparam logic [1:0] FN_DRAW  = 2'd1;
   localparam logic [1:0] FN_START = 2'd2;
   localparam logic [1:0] FN_NEXT  = 2'd3;

   // Blit mode codes; the spare code behaves as overlay.
   localparam logic [1:0] MODE_OVERWRITE = 2'd0;
   localparam logic [1:0] MODE_XOR       = 2'd1;
   localparam logic [1:0] MODE_OVERLAY   = 2'd2;
   localparam logic [1:0] MODE_SPARE     = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] CSR_FG_COLOR     = 3'd0;
   localparam logic [2:0] CSR_BG_COLOR     = 3'd1;
   localparam logic [2:0] CSR_BLIT_MODE    = 3'd2;
   localparam logic [2:0] CSR_SOURCE_MONO  = 3'd3;
   localparam logic [2:0] CSR_X_OFFSET     = 3'd4;
   localparam logic [2:0] CSR_Y_OFFSET     = 3'd5;
   localparam logic [2:0] CSR_IMAGE_WIDTH  = 3'd6;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd7;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic       src_bit;
      logic [7:0] src_red;
      logic [7:0] src_green;
      logic [7:0] src_blue;
   } req_type;

   typedef struct packed {
      logic       dc_bit;
      logic [7:0] spi_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [11:0]        fg_color;
      logic [11:0]        bg_color;
      logic [1:0]         blit_mode;
      logic               source_mono;
      logic signed [10:0] x_offset;
      logic signed [10:0] y_offset;
      logic [10:0]        image_width;
      logic [10:0]        image_height;
   } cfg_type;

   // Operations handed from the front end to the back end.
   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_WRITE,
      OP_XOR,
      OP_START,
      OP_NEXT
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  color;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CLEAR,
      BK_XOR,
      BK_START,
      BK_NEXT_A,
      BK_NEXT_B
   } back_state_type;

   // Word k of the refresh start command run.
   function automatic rsp_type start_word(input logic [2:0] k);
      rsp_type w;
      case (k)
         3'd0: w = '{dc_bit: 1'b0, spi_byte: CMD_COLUMN, last: 1'b0};
         3'd1: w = '{dc_bit: 1'b1, spi_byte: 8'h00, last: 1'b0};
         3'd2: w = '{dc_bit: 1'b1, spi_byte: 8'(DISP_WIDTH - 1), last: 1'b0};
         3'd3: w = '{dc_bit: 1'b0, spi_byte: CMD_PAGE, last: 1'b0};
         3'd4: w = '{dc_bit: 1'b1, spi_byte: 8'h00, last: 1'b0};
         3'd5: w = '{dc_bit: 1'b1, spi_byte: 8'(DISP_HEIGHT - 1), last: 1'b0};
         default: w = '{dc_bit: 1'b0, spi_byte: CMD_WRITE, last: 1'b1};
      endcase
      return w;
   endfunction

   // Nibble sel of a pixel: red, green, then blue.
   function automatic logic [3:0] nibble(input logic [PIX_W-1:0] pix,
                                         input logic [1:0] sel);
      logic [3:0] n;
      case (sel)
         2'd0: n = pix[11:8];
         2'd1: n = pix[7:4];
         default: n = pix[3:0];
      endcase
      return n;
   endfunction

endpackage

// File: rtl/rfb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rfb_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rfb_front.sv
// ----------------------------------------------------------------------------
// Blitter front end
// Accepts input transactions and turns them into frame store operations.
// ----------------------------------------------------------------------------
module rfb_front (
   input  rfb_pkg::cfg_type cfg,
   input  rfb_pkg::req_type req_data,
   output logic             keep,
   output rfb_pkg::cmd_type cmd
);
   import rfb_pkg::*;

   logic              on_display;
   logic signed [11:0] ix;
   logic signed [11:0] iy;
   logic              in_image;
   logic              set;
   logic [PIX_W-1:0]  src_color;
   logic [ADDR_W-1:0] idx;

   // Map the display pixel into image space and clip against the image.
   always_comb begin
      on_display = (req_data.pos_x < 8'(DISP_WIDTH)) && (req_data.pos_y < 8'(DISP_HEIGHT));
      ix = $signed({4'b0000, req_data.pos_x}) - 12'(cfg.x_offset);
      iy = $signed({4'b0000, req_data.pos_y}) - 12'(cfg.y_offset);
      in_image = !ix[11] && (ix[10:0] < cfg.image_width) &&
                 !iy[11] && (iy[10:0] < cfg.image_height);
      idx = ADDR_W'(int'(req_data.pos_y) * DISP_WIDTH + int'(req_data.pos_x));
   end

   // Source color and whether the pixel counts as set.
   always_comb begin
      if (cfg.source_mono) begin
         src_color = cfg.fg_color;
         set       = in_image && req_data.src_bit;
      end else begin
         src_color = {req_data.src_red[7:4], req_data.src_green[7:4], req_data.src_blue[7:4]};
         set       = in_image;
      end
   end

   // Classify the transaction; off-display draws and unset draws outside overwrite mode are dropped.
   always_comb begin
      keep      = 1'b1;
      cmd.op    = OP_NEXT;
      cmd.addr  = idx;
      cmd.color = src_color;
      case (req_data.func)
         FN_CLEAR: begin
            cmd.op = OP_CLEAR;
         end
         FN_DRAW: begin
            if (!on_display) begin
               keep = 1'b0;
            end else if (set) begin
               cmd.op = (cfg.blit_mode == MODE_XOR) ? OP_XOR : OP_WRITE;
            end else if (cfg.blit_mode == MODE_OVERWRITE) begin
               cmd.op    = OP_WRITE;
               cmd.color = cfg.bg_color;
            end else begin
               keep = 1'b0;
            end
         end
         FN_START: begin
            cmd.op = OP_START;
         end
         default: begin
            cmd.op = OP_NEXT;
         end
      endcase
   end

endmodule

// File: rtl/rfb_queue.sv
// ----------------------------------------------------------------------------
// Blitter operation queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rfb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rfb_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output rfb_pkg::cmd_type pop_cmd
);
   import rfb_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid) else $error("queue popped while empty");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue pushed while full");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
`endif

endmodule

// File: rtl/rfb_back.sv
// ----------------------------------------------------------------------------
// Blitter back end
// Carries out queued operations on the frame store and drives the result port.
// ----------------------------------------------------------------------------
module rfb_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [rfb_pkg::PIX_W-1:0] bg_color,
   input  logic                      q_valid,
   input  rfb_pkg::cmd_type          q_cmd,
   output logic                      q_pop,
   output logic                      wr_en,
   output logic [rfb_pkg::ADDR_W-1:0] wr_addr,
   output logic [rfb_pkg::PIX_W-1:0] wr_data,
   output logic                      rd_en,
   output logic [rfb_pkg::ADDR_W-1:0] rd_addr,
   input  logic [rfb_pkg::PIX_W-1:0] rd_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rfb_pkg::rsp_type          rsp_data
);
   import rfb_pkg::*;

   back_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [2:0]        start_cnt_ff, start_cnt_in;
   logic [CNT_W-1:0]  pix_ff, pix_in;
   logic [1:0]        sel_ff, sel_in;
   logic [ADDR_W-1:0] hold_addr_ff, hold_addr_in;
   logic [PIX_W-1:0]  hold_color_ff, hold_color_in;
   logic [3:0]        hi_ff, hi_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              out_free;
   logic [CNT_W-1:0]  pix_next;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pix_next  = pix_ff + CNT_W'(1);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer for clear sweeps, read-modify-writes and the refresh stream.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      start_cnt_in  = start_cnt_ff;
      pix_in        = pix_ff;
      sel_in        = sel_ff;
      hold_addr_in  = hold_addr_ff;
      hold_color_in = hold_color_ff;
      hi_in         = hi_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = q_cmd.addr;
      wr_data       = q_cmd.color;
      rd_en         = 1'b0;
      rd_addr       = q_cmd.addr;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_cmd.op)
                  OP_CLEAR: begin
                     clr_in   = '0;
                     state_in = BK_CLEAR;
                  end
                  OP_WRITE: begin
                     wr_en = 1'b1;
                  end
                  OP_XOR: begin
                     rd_en         = 1'b1;
                     hold_addr_in  = q_cmd.addr;
                     hold_color_in = q_cmd.color;
                     state_in      = BK_XOR;
                  end
                  OP_START: begin
                     pix_in       = '0;
                     sel_in       = 2'd0;
                     start_cnt_in = 3'd0;
                     state_in     = BK_START;
                  end
                  default: begin
                     // Refresh next is ignored once the frame has been sent.
                     if (pix_ff < CNT_W'(NPIX)) begin
                        rd_en    = 1'b1;
                        rd_addr  = pix_ff[ADDR_W-1:0];
                        state_in = BK_NEXT_A;
                     end
                  end
               endcase
            end
         end
         BK_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = bg_color;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(NPIX - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_XOR: begin
            wr_en    = 1'b1;
            wr_addr  = hold_addr_ff;
            wr_data  = rd_data ^ hold_color_ff;
            state_in = BK_IDLE;
         end
         BK_START: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = start_word(start_cnt_ff);
               start_cnt_in = start_cnt_ff + 3'd1;
               if (start_cnt_ff == 3'd6) begin
                  state_in = BK_IDLE;
               end
            end
         end
         BK_NEXT_A: begin
            if (sel_ff == 2'd2 && pix_next < CNT_W'(NPIX)) begin
               // The pair spans two pixels: fetch red of the next one.
               hi_in    = nibble(rd_data, 2'd2);
               rd_en    = 1'b1;
               rd_addr  = pix_next[ADDR_W-1:0];
               state_in = BK_NEXT_B;
            end else if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.dc_bit   = 1'b1;
               rsp_data_in.spi_byte = {nibble(rd_data, sel_ff), 4'h0};
               rsp_data_in.last     = 1'b0;
               state_in             = BK_IDLE;
               case (sel_ff)
                  2'd0: begin
                     rsp_data_in.spi_byte[3:0] = rd_data[7:4];
                     sel_in                    = 2'd2;
                  end
                  2'd1: begin
                     rsp_data_in.spi_byte[3:0] = rd_data[3:0];
                     rsp_data_in.last          = (pix_next >= CNT_W'(NPIX));
                     pix_in                    = pix_next;
                     sel_in                    = 2'd0;
                  end
                  default: begin
                     // Final odd nibble: low half padded with zero.
                     rsp_data_in.last = 1'b1;
                     pix_in           = pix_next;
                     sel_in           = 2'd0;
                  end
               endcase
            end
         end
         BK_NEXT_B: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.dc_bit   = 1'b1;
               rsp_data_in.spi_byte = {hi_ff, rd_data[11:8]};
               rsp_data_in.last     = 1'b0;
               pix_in               = pix_next;
               sel_in               = 2'd1;
               state_in             = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         clr_ff       <= '0;
         start_cnt_ff <= 3'd0;
         pix_ff       <= '0;
         sel_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         start_cnt_ff <= start_cnt_in;
         pix_ff       <= pix_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      hold_addr_ff  <= hold_addr_in;
      hold_color_ff <= hold_color_in;
      hi_ff         <= hi_in;
      rsp_data_ff   <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   a_start_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_START |-> start_cnt_ff <= 3'd6)
      else $error("start counter ran past the command run");
   a_pix_range: assert property (@(posedge clock) disable iff (reset)
      pix_ff <= CNT_W'(NPIX)) else $error("refresh pixel index past the frame");
   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      sel_ff != 2'd3) else $error("nibble select out of range");
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en)) else $error("frame store read and write in one cycle");
   a_next_b_follows: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == BK_NEXT_B) |-> $past(state_ff) == BK_NEXT_A && $past(sel_ff) == 2'd2)
      else $error("second pixel fetch without a straddling nibble pair");
`endif

endmodule

// File: rtl/rgb444_framebuffer_blitter_core.sv
// ----------------------------------------------------------------------------
// RGB444 frame buffer blitter core
// Keeps a 12-bit frame store, composites drawn pixels into it and streams it
// out as command and nibble-packed data bytes for a nine-bit serial link.
//
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  rfb_pkg::req_type
// rsp       out        rsp_valid/rsp_stall  rfb_pkg::rsp_type
// csr       in         csr_we               csr_index, csr_wdata
//
// A write draw is done in the back end as it is popped; an exclusive-or draw
// reads the frame store, then writes it back (one read port, registered read).
// Refresh next reads one pixel, or two when a nibble pair spans them, then
// emits a byte; refresh start emits seven command words. Clear sweeps the
// store one pixel per cycle. Reset is synchronous and clears control state
// only; the frame store holds nothing defined until cleared or drawn.
// A two-entry queue lets the input side keep accepting while the back end
// waits on rsp_stall.
// ----------------------------------------------------------------------------
module rgb444_framebuffer_blitter_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rfb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rfb_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [11:0]      csr_wdata
);
   import rfb_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   logic              keep;
   cmd_type           front_cmd;
   logic              q_full;
   logic              q_push;
   logic              q_pop;
   logic              q_valid;
   cmd_type           q_cmd;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [PIX_W-1:0]  wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [PIX_W-1:0]  rd_data;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FG_COLOR:     cfg_in.fg_color     = csr_wdata;
            CSR_BG_COLOR:     cfg_in.bg_color     = csr_wdata;
            CSR_BLIT_MODE:    cfg_in.blit_mode    = csr_wdata[1:0];
            CSR_SOURCE_MONO:  cfg_in.source_mono  = csr_wdata[0];
            CSR_X_OFFSET:     cfg_in.x_offset     = csr_wdata[10:0];
            CSR_Y_OFFSET:     cfg_in.y_offset     = csr_wdata[10:0];
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata[10:0];
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata[10:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fg_color     <= 12'hFFF;
         cfg_ff.bg_color     <= 12'hF00;
         cfg_ff.blit_mode    <= MODE_OVERWRITE;
         cfg_ff.source_mono  <= 1'b1;
         cfg_ff.x_offset     <= '0;
         cfg_ff.y_offset     <= '0;
         cfg_ff.image_width  <= '0;
         cfg_ff.image_height <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input side: a transaction is taken whenever the queue has room.
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full && keep;

   rfb_front u_front (
      .cfg      (cfg_ff),
      .req_data (req_data),
      .keep     (keep),
      .cmd      (front_cmd)
   );

   rfb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (q_cmd)
   );

   rfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .bg_color  (cfg_ff.bg_color),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rfb_ram #(
      .WIDTH (PIX_W),
      .DEPTH (NPIX)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// RGB444 frame buffer blitter core testbench
// Drives clear, draw and refresh transactions under several register
// settings, with random gaps and stalls on both channels. A scoreboard keeps
// its own copy of the frame store and compares each emitted word with the
// oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rfb_pkg::*;

   localparam int NIBBLES     = NPIX * 3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int CLEAR_WAIT  = NPIX + 200;

   // Scoreboard: frame store copy, register copy and expected words.
   class blit_scoreboard;
      logic [11:0]        pixels[NPIX];
      int unsigned        nibble_pos;
      logic [11:0]        fg_color;
      logic [11:0]        bg_color;
      logic [1:0]         blit_mode;
      logic               source_mono;
      logic signed [10:0] x_offset;
      logic signed [10:0] y_offset;
      logic [10:0]        image_width;
      logic [10:0]        image_height;
      rsp_type            pending[$];
      int                 errors;

      function new();
         foreach (pixels[i]) pixels[i] = '0;
         nibble_pos   = 0;
         fg_color     = 12'hFFF;
         bg_color     = 12'hF00;
         blit_mode    = MODE_OVERWRITE;
         source_mono  = 1'b1;
         x_offset     = '0;
         y_offset     = '0;
         image_width  = '0;
         image_height = '0;
         errors       = 0;
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      function void write_reg(logic [2:0] idx, logic [11:0] v);
         case (idx)
            CSR_FG_COLOR:     fg_color = v;
            CSR_BG_COLOR:     bg_color = v;
            CSR_BLIT_MODE:    blit_mode = v[1:0];
            CSR_SOURCE_MONO:  source_mono = v[0];
            CSR_X_OFFSET:     x_offset = v[10:0];
            CSR_Y_OFFSET:     y_offset = v[10:0];
            CSR_IMAGE_WIDTH:  image_width = v[10:0];
            default:          image_height = v[10:0];
         endcase
      endfunction

      function logic [3:0] nibble_of(int unsigned n);
         logic [11:0] p;
         p = pixels[n / 3];
         case (n % 3)
            0: return p[11:8];
            1: return p[7:4];
            default: return p[3:0];
         endcase
      endfunction

      function void add_word(logic dc, logic [7:0] b, logic lst);
         rsp_type w;
         w.dc_bit   = dc;
         w.spi_byte = b;
         w.last     = lst;
         pending.push_back(w);
      endfunction

      // Updates the store and queues the words one accepted transaction causes.
      function void note_request(req_type r);
         int          ix, iy, idx;
         logic        hit;
         logic [11:0] col, cur;
         logic [7:0]  b;
         case (r.func)
            FN_CLEAR: begin
               foreach (pixels[i]) pixels[i] = bg_color;
            end
            FN_DRAW: begin
               if (r.pos_x < DISP_WIDTH && r.pos_y < DISP_HEIGHT) begin
                  idx = int'(r.pos_y) * DISP_WIDTH + int'(r.pos_x);
                  ix  = int'(r.pos_x) - int'(x_offset);
                  iy  = int'(r.pos_y) - int'(y_offset);
                  hit = ix >= 0 && ix < int'(image_width) &&
                        iy >= 0 && iy < int'(image_height);
                  if (source_mono) begin
                     hit = hit && r.src_bit;
                     col = fg_color;
                  end else begin
                     col = {r.src_red[7:4], r.src_green[7:4], r.src_blue[7:4]};
                  end
                  cur = pixels[idx];
                  if (hit)
                     cur = (blit_mode == MODE_XOR) ? (cur ^ col) : col;
                  else if (blit_mode == MODE_OVERWRITE)
                     cur = bg_color;
                  pixels[idx] = cur;
               end
            end
            FN_START: begin
               nibble_pos = 0;
               add_word(1'b0, CMD_COLUMN, 1'b0);
               add_word(1'b1, 8'h00, 1'b0);
               add_word(1'b1, 8'(DISP_WIDTH - 1), 1'b0);
               add_word(1'b0, CMD_PAGE, 1'b0);
               add_word(1'b1, 8'h00, 1'b0);
               add_word(1'b1, 8'(DISP_HEIGHT - 1), 1'b0);
               add_word(1'b0, CMD_WRITE, 1'b1);
            end
            default: begin
               // Past the end of the frame nothing comes out.
               if (nibble_pos < NIBBLES) begin
                  b = {nibble_of(nibble_pos), 4'h0};
                  nibble_pos++;
                  if (nibble_pos < NIBBLES) begin
                     b[3:0] = nibble_of(nibble_pos);
                     nibble_pos++;
                  end
                  add_word(1'b1, b, nibble_pos >= NIBBLES);
               end
            end
         endcase
      endfunction

      task check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected word dc=%0b byte=%h last=%0b",
                             got.dc_bit, got.spi_byte, got.last));
         end else begin
            want = pending.pop_front();
            if (got.dc_bit !== want.dc_bit)
               report($sformatf("dc_bit %0b, expected %0b", got.dc_bit, want.dc_bit));
            if (got.spi_byte !== want.spi_byte)
               report($sformatf("spi_byte %h, expected %h", got.spi_byte, want.spi_byte));
            if (got.last !== want.last)
               report($sformatf("last %0b, expected %0b", got.last, want.last));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [11:0] csr_wdata = '0;

   blit_scoreboard board = new();
   bit          quiet = 1'b0;
   bit          clear_sent = 1'b0;
   int          stall_left = 0;
   int unsigned cycles = 0;

   rgb444_framebuffer_blitter_core uut (.*);

   always #5 clock = ~clock;

   // Cycle limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver stalls: mostly short bursts, now and then a long one.
   always @(negedge clock) begin
      if (quiet || reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
   end

   function int gap_len();
      if (quiet || $urandom_range(2) != 0) return 0;
      return ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(3, 1);
   endfunction

   // Presents one transaction and holds it until the block takes it.
   task send(req_type r);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
      if (r.func == FN_CLEAR) clear_sent = 1'b1;
   endtask

   task send_func(logic [1:0] f);
      req_type r;
      r = '0;
      r.func = f;
      send(r);
   endtask

   task draw(int x, int y, logic b, logic [7:0] red, logic [7:0] grn, logic [7:0] blu);
      req_type r;
      r.func      = FN_DRAW;
      r.pos_x     = 8'(x);
      r.pos_y     = 8'(y);
      r.src_bit   = b;
      r.src_red   = red;
      r.src_green = grn;
      r.src_blue  = blu;
      send(r);
   endtask

   // Waits until every expected word has come and the back end is done.
   task drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (clear_sent ? CLEAR_WAIT : 20) @(posedge clock);
      clear_sent = 1'b0;
   endtask

   task csr_write(logic [2:0] idx, logic [11:0] v);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      board.write_reg(idx, v);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task setup(logic [11:0] fg, logic [11:0] bg, logic [1:0] mode, logic mono,
              int xo, int yo, int w, int h);
      csr_write(CSR_FG_COLOR, fg);
      csr_write(CSR_BG_COLOR, bg);
      csr_write(CSR_BLIT_MODE, {10'd0, mode});
      csr_write(CSR_SOURCE_MONO, {11'd0, mono});
      csr_write(CSR_X_OFFSET, 12'(xo) & 12'h7FF);
      csr_write(CSR_Y_OFFSET, 12'(yo) & 12'h7FF);
      csr_write(CSR_IMAGE_WIDTH, 12'(w));
      csr_write(CSR_IMAGE_HEIGHT, 12'(h));
   endtask

   // Random traffic: mostly draws anywhere on the display, refresh runs with data.
   task random_traffic(int count);
      int k, pick, n;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(9);
         if (pick <= 5) begin
            draw($urandom_range(DISP_WIDTH - 1), $urandom_range(DISP_HEIGHT - 1),
                 1'($urandom_range(1)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
         end else if (pick == 6) begin
            send_func(FN_START);
            n = $urandom_range(8, 1);
            repeat (n) send_func(FN_NEXT);
         end else if (pick <= 8) begin
            send_func(FN_NEXT);
         end else begin
            // Positions off the display, high bits set.
            draw($urandom_range(255, DISP_WIDTH), $urandom_range(255),
                 1'($urandom_range(1)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset register values; fill the store before anything reads it.
      send_func(FN_CLEAR);
      drain();
      setup(12'hFFF, 12'h000, MODE_OVERWRITE, 1'b1, 0, 0, 2047, 2047);

      // Directed: corners, off-display positions, draws, refresh start and next.
      draw(0, 0, 1'b1, 8'h00, 8'h00, 8'h00);
      draw(1, 0, 1'b0, 8'hFF, 8'hFF, 8'hFF);
      draw(131, 131, 1'b1, 8'hFF, 8'h00, 8'hFF);
      draw(132, 5, 1'b1, 8'h12, 8'h34, 8'h56);
      draw(5, 132, 1'b1, 8'h12, 8'h34, 8'h56);
      draw(255, 255, 1'b1, 8'hFF, 8'hFF, 8'hFF);
      send_func(FN_START);
      repeat (4) send_func(FN_NEXT);
      drain();

      // Color source, exclusive-or, negative offsets at the low extreme.
      setup(12'h5A3, 12'h0F0, MODE_XOR, 1'b0, -1024, -1024, 2047, 2047);
      draw(0, 0, 1'b0, 8'hF0, 8'h0F, 8'hA5);
      draw(0, 0, 1'b1, 8'hF0, 8'h0F, 8'hA5);
      draw(2, 0, 1'b0, 8'h80, 8'h40, 8'h20);
      send_func(FN_START);
      repeat (3) send_func(FN_NEXT);
      random_traffic(12);
      drain();

      // Mono source, overlay, small image placed mid display.
      setup(12'h0C7, 12'hABC, MODE_OVERLAY, 1'b1, 20, 30, 60, 50);
      draw(19, 40, 1'b1, 8'h00, 8'h00, 8'h00);
      draw(20, 30, 1'b1, 8'h00, 8'h00, 8'h00);
      draw(79, 79, 1'b0, 8'h00, 8'h00, 8'h00);
      draw(80, 79, 1'b1, 8'h00, 8'h00, 8'h00);
      random_traffic(15);
      drain();

      // Mode three, empty image, new background, another clear.
      setup(12'h000, 12'h3E1, MODE_SPARE, 1'b1, 1023, 1023, 0, 0);
      send_func(FN_CLEAR);
      random_traffic(10);
      drain();

      // Overwrite with color source and a clipped window.
      setup(12'h842, 12'h7FF, MODE_OVERWRITE, 1'b0, -10, 40, 70, 60);
      random_traffic(15);
      drain();

      // Mono exclusive-or over the whole display.
      setup(12'hFFF, 12'h000, MODE_XOR, 1'b1, 0, 0, 132, 132);
      random_traffic(15);
      drain();

      // A short refresh run without idling on either side.
      quiet = 1'b1;
      send_func(FN_START);
      repeat (4) send_func(FN_NEXT);
      quiet = 1'b0;
      drain();

      if (board.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: rgb444_framebuffer_blitter_core.f
rtl/rfb_pkg.sv
rtl/rfb_ram.sv
rtl/rfb_front.sv
rtl/rfb_queue.sv
rtl/rfb_back.sv
rtl/rgb444_framebuffer_blitter_core.sv
test/tb_top.sv
